// ===== rtl/ip_address_literal_classifier_assert.svh =====
// Assertion macros for the IP address literal classifier.
`ifndef IP_ADDRESS_LITERAL_CLASSIFIER_ASSERT_SVH
`define IP_ADDRESS_LITERAL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication under the block reset.
`define IPALC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the block reset.
`define IPALC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipalc_pkg.sv =====
// Shared types, constants, the character decoder and tracker functions of the IP address literal classifier.
package ipalc_pkg;

  localparam int V4MaxValue  = 255;
  localparam int V4LastIdx   = 3;
  localparam int DigitsMax   = 3;
  localparam int V6Groups    = 8;
  localparam int GroupMaxLen = 4;
  localparam int GroupSatLen = 5;

  // Decoded character class.
  typedef struct packed {
    logic       digit;
    logic [3:0] dval;
    logic       hex;
    logic       dot;
    logic       colon;
    logic       last;
  } chr_t;

  // Dotted-quad tracker.
  typedef struct packed {
    logic [1:0] idx;
    logic [1:0] cnt;
    logic [9:0] val;
    logic       ok;
  } dot_t;

  // IPv6 tracker.
  typedef struct packed {
    logic [3:0] gc;
    logic [2:0] len;
    logic [1:0] run;
    logic       comp;
    logic       saw;
    logic       ok;
    logic       has_dot;
  } v6_t;

  localparam dot_t DotReset = '{idx: 2'd0, cnt: 2'd0, val: 10'd0, ok: 1'b1};
  localparam v6_t  V6Reset  = '{gc: 4'd0, len: 3'd0, run: 2'd0, comp: 1'b0, saw: 1'b0,
                                ok: 1'b1, has_dot: 1'b0};

  function automatic chr_t decode_char(logic [7:0] c, logic last);
    chr_t r;
    r.digit = (c >= 8'h30) && (c <= 8'h39);
    r.dval  = 4'(c - 8'h30);
    r.hex   = r.digit || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    r.dot   = (c == 8'h2e);
    r.colon = (c == 8'h3a);
    r.last  = last;
    return r;
  endfunction

  function automatic dot_t dotted_next(dot_t s, chr_t c);
    dot_t r;
    r = s;
    if (c.digit) begin
      if (s.cnt == 2'(DigitsMax)) begin
        r.ok = 1'b0;
      end else begin
        r.val = (s.val << 3) + (s.val << 1) + 10'(c.dval);
        r.cnt = s.cnt + 2'd1;
      end
    end else if (c.dot) begin
      if ((s.cnt == 2'd0) || (s.val > 10'(V4MaxValue)) || (s.idx == 2'(V4LastIdx))) begin
        r.ok = 1'b0;
      end else begin
        r.idx = s.idx + 2'd1;
        r.cnt = 2'd0;
        r.val = 10'd0;
      end
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic dotted_done(dot_t s);
    return s.ok && (s.idx == 2'(V4LastIdx)) && (s.cnt != 2'd0) && (s.val <= 10'(V4MaxValue));
  endfunction

  function automatic v6_t add_groups(v6_t s, logic [1:0] n);
    v6_t r;
    r = s;
    if (({1'b0, s.gc} + 5'(n)) > 5'(V6Groups)) begin
      r.ok = 1'b0;
    end else begin
      r.gc = s.gc + 4'(n);
    end
    return r;
  endfunction

endpackage

// ===== rtl/ipalc_front.sv =====
// Front end: takes character beats and decodes them into character classes.
module ipalc_front import ipalc_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       push_o,
  output chr_t       push_data_o,
  input  logic       q_full_i
);

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign push_data_o = decode_char(char_code_i, is_last_i);

endmodule

// ===== rtl/ipalc_queue.sv =====
// Two-entry queue of decoded characters between front and back end.
module ipalc_queue import ipalc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  chr_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output chr_t pop_data_o
);

  chr_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/ipalc_back.sv =====
// Back end: runs the IPv4 and IPv6 trackers and holds the result register.
module ipalc_back import ipalc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  chr_t q_data_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic is_ipv4_o,
  output logic is_ipv6_o,
  output logic direct_address_o
);

  dot_t v4_q, v4_d;
  dot_t tail_q, tail_d;
  v6_t  v6_q, v6_d;
  logic out_valid_q, out_valid_d;
  logic ipv4_q, ipv4_d;
  logic ipv6_q, ipv6_d;

  assign pop_o = q_valid_i && (!q_data_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    v4_d   = v4_q;
    tail_d = tail_q;
    v6_d   = v6_q;
    ipv4_d = ipv4_q;
    ipv6_d = ipv6_q;
    out_valid_d = (out_valid_q && !out_ready_i);

    if (pop_o) begin
      v4_d = dotted_next(v4_q, q_data_i);

      if (q_data_i.colon) begin
        if ((v6_d.len != 3'd0) || v6_d.has_dot) begin
          if (v6_d.has_dot || (v6_d.len > 3'(GroupMaxLen))) begin
            v6_d.ok = 1'b0;
          end else begin
            v6_d = add_groups(v6_d, 2'd1);
          end
        end
        v6_d.len     = 3'd0;
        v6_d.has_dot = 1'b0;
        tail_d       = DotReset;
        if (v6_d.run >= 2'd2) begin
          v6_d.ok  = 1'b0;
          v6_d.run = 2'd3;
        end else begin
          v6_d.run = v6_d.run + 2'd1;
          if (v6_d.run == 2'd2) begin
            if (v6_d.comp) begin
              v6_d.ok = 1'b0;
            end
            v6_d.comp = 1'b1;
          end
        end
        v6_d.saw = 1'b1;
      end else begin
        if ((v6_d.run == 2'd1) && (v6_d.gc == 4'd0) && !v6_d.comp) begin
          v6_d.ok = 1'b0;
        end
        v6_d.run = 2'd0;
        if (q_data_i.dot) begin
          v6_d.has_dot = 1'b1;
        end else if (!q_data_i.hex) begin
          v6_d.ok = 1'b0;
        end
        if (v6_d.len < 3'(GroupSatLen)) begin
          v6_d.len = v6_d.len + 3'd1;
        end
        tail_d = dotted_next(tail_q, q_data_i);
      end

      if (q_data_i.last) begin
        if (v6_d.run == 2'd1) begin
          v6_d.ok = 1'b0;
        end
        if (v6_d.run == 2'd0) begin
          if (v6_d.has_dot) begin
            if (dotted_done(tail_d)) begin
              v6_d = add_groups(v6_d, 2'd2);
            end else begin
              v6_d.ok = 1'b0;
            end
          end else if ((v6_d.len >= 3'd1) && (v6_d.len <= 3'(GroupMaxLen))) begin
            v6_d = add_groups(v6_d, 2'd1);
          end else begin
            v6_d.ok = 1'b0;
          end
        end
        ipv4_d = dotted_done(v4_d);
        ipv6_d = v6_d.ok && v6_d.saw &&
                 (v6_d.comp ? (v6_d.gc < 4'(V6Groups)) : (v6_d.gc == 4'(V6Groups)));
        out_valid_d = 1'b1;
        v4_d   = DotReset;
        tail_d = DotReset;
        v6_d   = V6Reset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q        <= DotReset;
      tail_q      <= DotReset;
      v6_q        <= V6Reset;
      out_valid_q <= 1'b0;
    end else begin
      v4_q        <= v4_d;
      tail_q      <= tail_d;
      v6_q        <= v6_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ipv4_q <= ipv4_d;
    ipv6_q <= ipv6_d;
  end

  assign out_valid_o      = out_valid_q;
  assign is_ipv4_o        = ipv4_q;
  assign is_ipv6_o        = ipv6_q;
  assign direct_address_o = ipv4_q || ipv6_q;

endmodule

// ===== rtl/ip_address_literal_classifier.sv =====
// Top level of the IP address literal classifier.
//
// Input channel: one character beat per cycle (char_code_i, is_last_i) under
// in_valid_i/in_ready_o. Output channel: one result beat per host text
// (is_ipv4_o, is_ipv6_o, direct_address_o) under out_valid_o/out_ready_i.
// Throughput: one character per cycle, including back-to-back texts, unless a held result stalls the trackers.
// The last character beat of a text first passes through the decode queue; the
// tracker stage loads the result register at the edge that pops it from the queue.
// A two-entry queue sits between the character decoder and the trackers; the
// tracker stage stalls only on a last character while an untaken result is
// held, and the input stalls once the queue fills.
// Reset clears the queue, the trackers and the result valid; the block accepts
// characters once reset is released.
module ip_address_literal_classifier import ipalc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_ipv4_o,
  output logic       is_ipv6_o,
  output logic       direct_address_o
);

  `include "ip_address_literal_classifier_assert.svh"

  logic push;
  chr_t push_data;
  logic q_full;
  logic pop;
  logic q_valid;
  chr_t q_data;

  ipalc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  ipalc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  ipalc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_ipv4_o        (is_ipv4_o),
    .is_ipv6_o        (is_ipv6_o),
    .direct_address_o (direct_address_o)
  );

  `IPALC_ASSERT_IMP(a_direct_is_or, out_valid_o,
    direct_address_o == (is_ipv4_o || is_ipv6_o), "direct_address mismatch")
  `IPALC_ASSERT_IMP(a_v4_v6_exclusive, out_valid_o,
    !(is_ipv4_o && is_ipv6_o), "text classified as both IPv4 and IPv6")
  `IPALC_ASSERT_IMP(a_full_has_data, !in_ready_o, q_valid, "queue full but empty")
  `IPALC_ASSERT_NXT(a_last_pop_loads, pop && q_data.last, out_valid_o,
    "last character popped without a result")

endmodule
